// ----- sv/assert_macros.svh -----
// Assertion helper macros for the sorted expiry timer queue.
// Included by files that carry concurrent assertions; they expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/setq_pkg.sv -----
// Shared types and constants for the sorted expiry timer queue.
// No dependencies; used by the interfaces, the controller, the datapath and the top level.
`default_nettype none

package setq_pkg;

    localparam int CMD_W    = 2;
    localparam int CLIENT_W = 10;
    localparam int TIME_W   = 32;
    localparam int STATUS_W = 3;

    // Request command codes.
    localparam logic [CMD_W-1:0] CMD_ADD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEL  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EXPIRED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NONE     = 3'd4;

    typedef struct packed {
        logic [TIME_W-1:0]   expiry;
        logic [CLIENT_W-1:0] client;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_ADD_PRIME,
        S_ADD_CMP,
        S_ADD_PUT,
        S_DEL_PRIME,
        S_DEL_CMP,
        S_TICK_PRIME,
        S_TICK_CMP,
        S_EMIT_RD,
        S_EMIT_OUT,
        S_RESP
    } ctrl_state_t;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_ZERO,
        IDX_COUNT_M1,
        IDX_INC,
        IDX_DEC
    } idx_op_t;

    typedef enum logic [1:0] {
        WR_UP,
        WR_DOWN,
        WR_ZERO
    } wr_sel_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC,
        CNT_POP
    } cnt_op_t;

    typedef enum logic [2:0] {
        RES_ADD_OK,
        RES_FULL,
        RES_DEL_OK,
        RES_NOTFOUND,
        RES_NONE
    } res_kind_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      load_req;
        idx_op_t   idx_op;
        logic      wr_en;
        wr_sel_t   wr_sel;
        logic      wr_new;
        logic      set_found;
        logic      nexp_inc;
        logic      res_set;
        res_kind_t res_kind;
        logic      out_load_res;
        logic      out_load_exp;
        cnt_op_t   cnt_op;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [CMD_W-1:0] req_cmd;
        logic             empty;
        logic             full;
        logic             rd_later;
        logic             rd_match;
        logic             rd_expired;
        logic             rd_at_end;
        logic             rd_at_zero;
        logic             found;
        logic             n_zero;
        logic             emit_last;
        logic             out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// ----- sv/setq_req_if.sv -----
// Request channel of the sorted expiry timer queue: valid, ready and the request payload.
// Depends on setq_pkg for field widths.
`default_nettype none

interface setq_req_if;
    logic                           valid;
    logic                           ready;
    logic [setq_pkg::CMD_W-1:0]     cmd;
    logic [setq_pkg::CLIENT_W-1:0]  client_id;
    logic [setq_pkg::TIME_W-1:0]    expire_time;
    logic [setq_pkg::TIME_W-1:0]    now_time;

    modport source (output valid, output cmd, output client_id, output expire_time,
                    output now_time, input ready);
    modport sink   (input valid, input cmd, input client_id, input expire_time,
                    input now_time, output ready);
endinterface

`default_nettype wire

// ----- sv/setq_res_if.sv -----
// Result channel of the sorted expiry timer queue: valid, ready and the result payload.
// Depends on setq_pkg for field widths.
`default_nettype none

interface setq_res_if;
    logic                           valid;
    logic                           ready;
    logic [setq_pkg::STATUS_W-1:0]  status;
    logic [setq_pkg::CLIENT_W-1:0]  client_id_out;
    logic [setq_pkg::TIME_W-1:0]    expire_out;
    logic                           last;

    modport source (output valid, output status, output client_id_out, output expire_out,
                    output last, input ready);
    modport sink   (input valid, input status, input client_id_out, input expire_out,
                    input last, output ready);
endinterface

`default_nettype wire

// ----- sv/setq_ctrl.sv -----
// Controller state machine of the sorted expiry timer queue.
// Depends on setq_pkg; drives the datapath through dp_cmd_t and reads dp_stat_t.
`default_nettype none

module setq_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire setq_pkg::dp_stat_t stat,
    output setq_pkg::dp_cmd_t       cmd
);

    setq_pkg::ctrl_state_t state_reg;
    setq_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= setq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            setq_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = setq_pkg::S_DECODE;
                end
            end
            setq_pkg::S_DECODE:
            begin
                case (stat.req_cmd)
                    setq_pkg::CMD_ADD:
                    begin
                        if (stat.full)
                        begin
                            state_next = setq_pkg::S_RESP;
                        end
                        else if (stat.empty)
                        begin
                            state_next = setq_pkg::S_ADD_PUT;
                        end
                        else
                        begin
                            state_next = setq_pkg::S_ADD_PRIME;
                        end
                    end
                    setq_pkg::CMD_DEL:
                    begin
                        state_next = stat.empty ? setq_pkg::S_RESP : setq_pkg::S_DEL_PRIME;
                    end
                    setq_pkg::CMD_TICK:
                    begin
                        state_next = stat.empty ? setq_pkg::S_RESP : setq_pkg::S_TICK_PRIME;
                    end
                    default:
                    begin
                        state_next = setq_pkg::S_IDLE;
                    end
                endcase
            end
            setq_pkg::S_ADD_PRIME:
            begin
                state_next = setq_pkg::S_ADD_CMP;
            end
            setq_pkg::S_ADD_CMP:
            begin
                if (!stat.rd_later)
                begin
                    state_next = setq_pkg::S_RESP;
                end
                else if (stat.rd_at_zero)
                begin
                    state_next = setq_pkg::S_ADD_PUT;
                end
            end
            setq_pkg::S_ADD_PUT:
            begin
                state_next = setq_pkg::S_RESP;
            end
            setq_pkg::S_DEL_PRIME:
            begin
                state_next = setq_pkg::S_DEL_CMP;
            end
            setq_pkg::S_DEL_CMP:
            begin
                if (stat.rd_at_end)
                begin
                    state_next = setq_pkg::S_RESP;
                end
            end
            setq_pkg::S_TICK_PRIME:
            begin
                state_next = setq_pkg::S_TICK_CMP;
            end
            setq_pkg::S_TICK_CMP:
            begin
                if (stat.rd_expired)
                begin
                    if (stat.rd_at_end)
                    begin
                        state_next = setq_pkg::S_EMIT_RD;
                    end
                end
                else
                begin
                    state_next = stat.n_zero ? setq_pkg::S_RESP : setq_pkg::S_EMIT_RD;
                end
            end
            setq_pkg::S_EMIT_RD:
            begin
                state_next = setq_pkg::S_EMIT_OUT;
            end
            setq_pkg::S_EMIT_OUT:
            begin
                if (stat.out_free)
                begin
                    state_next = stat.emit_last ? setq_pkg::S_IDLE : setq_pkg::S_EMIT_RD;
                end
            end
            setq_pkg::S_RESP:
            begin
                if (stat.out_free)
                begin
                    state_next = setq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = setq_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        in_ready     = 1'b0;
        cmd          = '0;
        cmd.idx_op   = setq_pkg::IDX_HOLD;
        cmd.wr_sel   = setq_pkg::WR_UP;
        cmd.res_kind = setq_pkg::RES_NONE;
        cmd.cnt_op   = setq_pkg::CNT_HOLD;
        case (state_reg)
            setq_pkg::S_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.load_req = in_valid;
                cmd.idx_op   = setq_pkg::IDX_ZERO;
            end
            setq_pkg::S_DECODE:
            begin
                case (stat.req_cmd)
                    setq_pkg::CMD_ADD:
                    begin
                        if (stat.full)
                        begin
                            cmd.res_set  = 1'b1;
                            cmd.res_kind = setq_pkg::RES_FULL;
                        end
                        else if (!stat.empty)
                        begin
                            cmd.idx_op = setq_pkg::IDX_COUNT_M1;
                        end
                    end
                    setq_pkg::CMD_DEL:
                    begin
                        if (stat.empty)
                        begin
                            cmd.res_set  = 1'b1;
                            cmd.res_kind = setq_pkg::RES_NOTFOUND;
                        end
                    end
                    setq_pkg::CMD_TICK:
                    begin
                        if (stat.empty)
                        begin
                            cmd.res_set  = 1'b1;
                            cmd.res_kind = setq_pkg::RES_NONE;
                        end
                    end
                    default:
                    begin
                        cmd.load_req = 1'b0;
                    end
                endcase
            end
            setq_pkg::S_ADD_PRIME:
            begin
                cmd.idx_op = setq_pkg::IDX_DEC;
            end
            setq_pkg::S_ADD_CMP:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = setq_pkg::WR_UP;
                if (stat.rd_later)
                begin
                    cmd.wr_new = 1'b0;
                    cmd.idx_op = setq_pkg::IDX_DEC;
                end
                else
                begin
                    cmd.wr_new   = 1'b1;
                    cmd.cnt_op   = setq_pkg::CNT_INC;
                    cmd.res_set  = 1'b1;
                    cmd.res_kind = setq_pkg::RES_ADD_OK;
                end
            end
            setq_pkg::S_ADD_PUT:
            begin
                cmd.wr_en    = 1'b1;
                cmd.wr_sel   = setq_pkg::WR_ZERO;
                cmd.wr_new   = 1'b1;
                cmd.cnt_op   = setq_pkg::CNT_INC;
                cmd.res_set  = 1'b1;
                cmd.res_kind = setq_pkg::RES_ADD_OK;
            end
            setq_pkg::S_DEL_PRIME:
            begin
                cmd.idx_op = setq_pkg::IDX_INC;
            end
            setq_pkg::S_DEL_CMP:
            begin
                if (!stat.found && stat.rd_match)
                begin
                    cmd.set_found = 1'b1;
                end
                else if (stat.found)
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = setq_pkg::WR_DOWN;
                end
                if (stat.rd_at_end)
                begin
                    cmd.res_set = 1'b1;
                    if (stat.found || stat.rd_match)
                    begin
                        cmd.cnt_op   = setq_pkg::CNT_DEC;
                        cmd.res_kind = setq_pkg::RES_DEL_OK;
                    end
                    else
                    begin
                        cmd.res_kind = setq_pkg::RES_NOTFOUND;
                    end
                end
                else
                begin
                    cmd.idx_op = setq_pkg::IDX_INC;
                end
            end
            setq_pkg::S_TICK_PRIME:
            begin
                cmd.idx_op = setq_pkg::IDX_INC;
            end
            setq_pkg::S_TICK_CMP:
            begin
                if (stat.rd_expired)
                begin
                    cmd.nexp_inc = 1'b1;
                    cmd.idx_op   = stat.rd_at_end ? setq_pkg::IDX_ZERO : setq_pkg::IDX_INC;
                end
                else if (stat.n_zero)
                begin
                    cmd.res_set  = 1'b1;
                    cmd.res_kind = setq_pkg::RES_NONE;
                end
                else
                begin
                    cmd.idx_op = setq_pkg::IDX_ZERO;
                end
            end
            setq_pkg::S_EMIT_RD:
            begin
                cmd.idx_op = setq_pkg::IDX_HOLD;
            end
            setq_pkg::S_EMIT_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load_exp = 1'b1;
                    if (stat.emit_last)
                    begin
                        cmd.cnt_op = setq_pkg::CNT_POP;
                    end
                    else
                    begin
                        cmd.idx_op = setq_pkg::IDX_INC;
                    end
                end
            end
            setq_pkg::S_RESP:
            begin
                cmd.out_load_res = stat.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/setq_dp.sv -----
// Datapath of the sorted expiry timer queue: circular entry memory, scan index,
// fill count, result holding registers and the output register. Depends on setq_pkg.
`default_nettype none

module setq_dp #(
    parameter int DEPTH = 32
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [setq_pkg::CMD_W-1:0]     in_cmd,
    input  wire logic [setq_pkg::CLIENT_W-1:0]  in_client_id,
    input  wire logic [setq_pkg::TIME_W-1:0]    in_expire_time,
    input  wire logic [setq_pkg::TIME_W-1:0]    in_now_time,
    input  wire setq_pkg::dp_cmd_t              cmd,
    output setq_pkg::dp_stat_t                  stat,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [setq_pkg::STATUS_W-1:0]       out_status,
    output logic [setq_pkg::CLIENT_W-1:0]       out_client_id,
    output logic [setq_pkg::TIME_W-1:0]         out_expire,
    output logic                                out_last
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
    localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(DEPTH);
    localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);

    // Logical position to physical slot: base plus offset, wrapped once.
    function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] base,
                                              input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= DEPTH_SUM)
        begin
            sum = sum - DEPTH_SUM;
        end
        return sum[IDX_W-1:0];
    endfunction

    setq_pkg::entry_t mem [DEPTH];
    setq_pkg::entry_t rd_data_reg;

    logic [setq_pkg::CMD_W-1:0]     req_cmd_reg;
    logic [setq_pkg::CLIENT_W-1:0]  req_client_reg;
    logic [setq_pkg::TIME_W-1:0]    req_expiry_reg;
    logic [setq_pkg::TIME_W-1:0]    req_now_reg;
    logic [setq_pkg::TIME_W-1:0]    hit_expiry_reg;

    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] rd_idx_reg;
    logic [CNT_W-1:0] nexp_reg, nexp_next;
    logic             found_reg, found_next;

    logic [setq_pkg::STATUS_W-1:0]  res_status_reg;
    logic [setq_pkg::CLIENT_W-1:0]  res_client_reg;
    logic [setq_pkg::TIME_W-1:0]    res_expiry_reg;

    logic                           out_valid_reg, out_valid_next;
    logic [setq_pkg::STATUS_W-1:0]  out_status_reg;
    logic [setq_pkg::CLIENT_W-1:0]  out_client_reg;
    logic [setq_pkg::TIME_W-1:0]    out_expiry_reg;
    logic                           out_last_reg;

    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    logic [CNT_W-1:0] wr_pos;
    setq_pkg::entry_t wr_data;
    setq_pkg::entry_t new_entry;
    logic             out_free;

    assign new_entry.expiry = req_expiry_reg;
    assign new_entry.client = req_client_reg;
    assign wr_data          = cmd.wr_new ? new_entry : rd_data_reg;
    assign rd_addr          = phys(head_reg, idx_reg);
    assign out_free         = !out_valid_reg || out_ready;

    always_comb
    begin
        case (cmd.wr_sel)
            setq_pkg::WR_UP:   wr_pos = rd_idx_reg + ONE_CNT;
            setq_pkg::WR_DOWN: wr_pos = rd_idx_reg - ONE_CNT;
            default:           wr_pos = '0;
        endcase
        wr_addr = phys(head_reg, wr_pos);
    end

    // Entry memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        case (cmd.idx_op)
            setq_pkg::IDX_ZERO:     idx_next = '0;
            setq_pkg::IDX_COUNT_M1: idx_next = count_reg - ONE_CNT;
            setq_pkg::IDX_INC:      idx_next = idx_reg + ONE_CNT;
            setq_pkg::IDX_DEC:      idx_next = (idx_reg == '0) ? '0 : idx_reg - ONE_CNT;
            default:                idx_next = idx_reg;
        endcase

        head_next  = head_reg;
        count_next = count_reg;
        case (cmd.cnt_op)
            setq_pkg::CNT_INC: count_next = count_reg + ONE_CNT;
            setq_pkg::CNT_DEC: count_next = count_reg - ONE_CNT;
            setq_pkg::CNT_POP:
            begin
                count_next = count_reg - nexp_reg;
                head_next  = phys(head_reg, nexp_reg);
            end
            default:           count_next = count_reg;
        endcase

        found_next = found_reg;
        nexp_next  = nexp_reg;
        if (cmd.load_req)
        begin
            found_next = 1'b0;
            nexp_next  = '0;
        end
        else
        begin
            if (cmd.set_found)
            begin
                found_next = 1'b1;
            end
            if (cmd.nexp_inc)
            begin
                nexp_next = nexp_reg + ONE_CNT;
            end
        end

        if (cmd.out_load_res || cmd.out_load_exp)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            rd_idx_reg    <= '0;
            nexp_reg      <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            rd_idx_reg    <= idx_reg;
            nexp_reg      <= nexp_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, loaded on enables only.
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_cmd_reg    <= in_cmd;
            req_client_reg <= in_client_id;
            req_expiry_reg <= in_expire_time;
            req_now_reg    <= in_now_time;
        end
        if (cmd.set_found)
        begin
            hit_expiry_reg <= rd_data_reg.expiry;
        end
        if (cmd.res_set)
        begin
            case (cmd.res_kind)
                setq_pkg::RES_ADD_OK:
                begin
                    res_status_reg <= setq_pkg::ST_OK;
                    res_client_reg <= req_client_reg;
                    res_expiry_reg <= req_expiry_reg;
                end
                setq_pkg::RES_FULL:
                begin
                    res_status_reg <= setq_pkg::ST_FULL;
                    res_client_reg <= req_client_reg;
                    res_expiry_reg <= req_expiry_reg;
                end
                setq_pkg::RES_DEL_OK:
                begin
                    res_status_reg <= setq_pkg::ST_OK;
                    res_client_reg <= req_client_reg;
                    res_expiry_reg <= found_reg ? hit_expiry_reg : rd_data_reg.expiry;
                end
                setq_pkg::RES_NOTFOUND:
                begin
                    res_status_reg <= setq_pkg::ST_NOTFOUND;
                    res_client_reg <= req_client_reg;
                    res_expiry_reg <= '0;
                end
                default:
                begin
                    res_status_reg <= setq_pkg::ST_NONE;
                    res_client_reg <= '0;
                    res_expiry_reg <= '0;
                end
            endcase
        end
        if (cmd.out_load_res)
        begin
            out_status_reg <= res_status_reg;
            out_client_reg <= res_client_reg;
            out_expiry_reg <= res_expiry_reg;
            out_last_reg   <= 1'b1;
        end
        else if (cmd.out_load_exp)
        begin
            out_status_reg <= setq_pkg::ST_EXPIRED;
            out_client_reg <= rd_data_reg.client;
            out_expiry_reg <= rd_data_reg.expiry;
            out_last_reg   <= (idx_reg == nexp_reg - ONE_CNT);
        end
    end

    always_comb
    begin
        stat.req_cmd    = req_cmd_reg;
        stat.empty      = (count_reg == '0);
        stat.full       = (count_reg == DEPTH_CNT);
        stat.rd_later   = (rd_data_reg.expiry > req_expiry_reg);
        stat.rd_match   = (rd_data_reg.client == req_client_reg);
        stat.rd_expired = (rd_data_reg.expiry <= req_now_reg);
        stat.rd_at_end  = (rd_idx_reg == count_reg - ONE_CNT);
        stat.rd_at_zero = (rd_idx_reg == '0);
        stat.found      = found_reg;
        stat.n_zero     = (nexp_reg == '0);
        stat.emit_last  = (idx_reg == nexp_reg - ONE_CNT);
        stat.out_free   = out_free;
    end

    assign out_valid     = out_valid_reg;
    assign out_status    = out_status_reg;
    assign out_client_id = out_client_reg;
    assign out_expire    = out_expiry_reg;
    assign out_last      = out_last_reg;

endmodule

`default_nettype wire

// ----- sv/sorted_expiry_timer_queue.sv -----
// Each request is decoded, then an add walks back from the tail, shifting later entries up, and
// writes the new one, a delete scans every entry, and a tick scans the due entries from the head
// and then reads and emits each as its own result; an add to a full queue, or a delete or tick
// on an empty queue, goes straight to its result. Throughput: one request at a time, the next
// taken the cycle after the last result is loaded.
// Reset: rst_n clears fill count, ring head and control; entries past the count never matter.
`default_nettype none
`include "assert_macros.svh"

module sorted_expiry_timer_queue #(
    parameter int DEPTH = 32
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    setq_req_if.sink    req,
    setq_res_if.source  res
);

    // The controller sequences each request as a walk over the entry memory; the
    // datapath holds the entries in a ring whose head moves forward when a tick
    // pops expired timers, so popping costs no data movement. Add shifts later
    // entries up one slot while it walks back from the tail, and delete shifts
    // the entries after the removed one down while it walks forward.
    setq_pkg::dp_cmd_t  dp_cmd;
    setq_pkg::dp_stat_t dp_stat;

    // Any load of the output register, and any write that shifts or inserts for an add.
    logic out_load;
    logic insert_wr;

    assign out_load  = dp_cmd.out_load_res || dp_cmd.out_load_exp;
    assign insert_wr = dp_cmd.wr_en && (dp_cmd.wr_sel == setq_pkg::WR_UP ||
                                        dp_cmd.wr_sel == setq_pkg::WR_ZERO);

    setq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .stat     (dp_stat),
        .cmd      (dp_cmd)
    );

    setq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_cmd         (req.cmd),
        .in_client_id   (req.client_id),
        .in_expire_time (req.expire_time),
        .in_now_time    (req.now_time),
        .cmd            (dp_cmd),
        .stat           (dp_stat),
        .out_valid      (res.valid),
        .out_ready      (res.ready),
        .out_status     (res.status),
        .out_client_id  (res.client_id_out),
        .out_expire     (res.expire_out),
        .out_last       (res.last)
    );

    // A request that is taken keeps the block busy for at least the next cycle.
    `ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready, "accepted while busy")

    // The output register is loaded only when its previous result has gone or is leaving.
    `ASSERT_IMPLIES(a_load_when_free, out_load, dp_stat.out_free, "output overwrite")

    // Popping expired timers needs at least one counted expiry.
    `ASSERT_IMPLIES(a_pop_nonzero, dp_cmd.cnt_op == setq_pkg::CNT_POP, !dp_stat.n_zero, "empty pop")

    // An add never shifts or inserts into a full queue.
    `ASSERT_IMPLIES(a_no_insert_full, insert_wr, !dp_stat.full, "insert while full")

endmodule

`default_nettype wire
